// File: src/triangle_plane_and_bounds_unit_defines.svh
// Assertion macros used by the port-level checker of the triangle plane and bounds unit.
`ifndef TRIANGLE_PLANE_AND_BOUNDS_UNIT_DEFINES_SVH
`define TRIANGLE_PLANE_AND_BOUNDS_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TPB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("triangle plane unit check failed");

// Next-cycle implication, checked outside reset.
`define TPB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("triangle plane unit check failed");

// Condition that must hold in the cycle after reset is seen.
`define TPB_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("triangle plane unit reset check failed");

`endif

// File: src/tpb_pkg.sv
// Shared types, widths, constants and states of the triangle plane and bounds unit.
package tpb_pkg;

  localparam int COORD_W   = 32;
  localparam int NFB       = 30;
  localparam int NORM_W    = NFB + 2;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int MUL_W     = 2 * DIFF_W;
  localparam int CROSS_W   = MUL_W + 1;
  localparam int MAG_W     = CROSS_W - 1;
  localparam int S_W       = 31;
  localparam int SQ_W      = 2 * S_W;
  localparam int RAD_W     = 64;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int PROD_W    = COORD_W + NORM_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int DIV_CNT_W = $clog2(NFB + 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t vec3_t [3];
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [NORM_W-1:0] norm_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Sequencer states, one item in flight at a time.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CROSS_MUL,
    S_CROSS_SUB,
    S_ABS,
    S_SHIFT,
    S_SQUARE,
    S_SUM,
    S_SQRT,
    S_DIV_INIT,
    S_DIV,
    S_ROUND,
    S_DOT,
    S_ACC,
    S_OUT
  } state_t;

  // Step strobes that the sequencer sends to every lane.
  typedef struct packed {
    logic cross_mul;
    logic cross_sub;
    logic take_abs;
    logic shift;
    logic square;
    logic div_init;
    logic div_step;
    logic div_round;
    logic dot;
  } lane_ctrl_t;

endpackage

// File: src/tpb_lane.sv
// One axis lane: cross product term, magnitude scaling, square, division and dot term.
module tpb_lane (
  input  logic                        clk,
  input  tpb_pkg::lane_ctrl_t         ctrl,
  input  tpb_pkg::diff_t              a_p,
  input  tpb_pkg::diff_t              b_q,
  input  tpb_pkg::diff_t              a_r,
  input  tpb_pkg::diff_t              b_t,
  input  logic [tpb_pkg::ROOT_W-1:0]  den,
  input  tpb_pkg::coord_t             v0,
  output logic                        wide,
  output logic                        nonzero,
  output logic [tpb_pkg::SQ_W-1:0]    sq,
  output tpb_pkg::norm_t              n,
  output logic signed [tpb_pkg::PROD_W-1:0] prod
);
  import tpb_pkg::*;

  logic signed [MUL_W-1:0]   m1;
  logic signed [MUL_W-1:0]   m2;
  logic signed [CROSS_W-1:0] c;
  logic                      neg;
  logic [MAG_W-1:0]          mag;
  logic [S_W-1:0]            s;
  logic [ROOT_W-1:0]         r;
  logic [NORM_W-1:0]         q;
  logic [ROOT_W:0]           r2;
  logic [ROOT_W:0]           den_x;
  logic [ROOT_W:0]           s_x;

  assign s       = mag[S_W-1:0];
  assign wide    = |mag[MAG_W-1:S_W];
  assign nonzero = |mag;
  assign r2      = {r, 1'b0};
  assign den_x   = {1'b0, den};
  assign s_x     = (ROOT_W+1)'(s);
  assign n       = neg ? $signed(-q) : $signed(q);

  // Each strobe advances one step of the per-axis work.
  always_ff @(posedge clk) begin
    if (ctrl.cross_mul) begin
      m1 <= a_p * b_q;
      m2 <= a_r * b_t;
    end
    if (ctrl.cross_sub) begin
      c <= CROSS_W'(m1) - CROSS_W'(m2);
    end
    if (ctrl.take_abs) begin
      neg <= c[CROSS_W-1];
      mag <= c[CROSS_W-1] ? MAG_W'(-c) : MAG_W'(c);
    end else if (ctrl.shift) begin
      mag <= mag >> 1;
    end
    if (ctrl.square) begin
      sq <= SQ_W'(s) * SQ_W'(s);
    end
    // Restoring division of the scaled magnitude by the length.
    if (ctrl.div_init) begin
      if (s_x >= den_x) begin
        q <= NORM_W'(1);
        r <= ROOT_W'(s_x - den_x);
      end else begin
        q <= '0;
        r <= ROOT_W'(s);
      end
    end else if (ctrl.div_step) begin
      if (r2 >= den_x) begin
        r <= ROOT_W'(r2 - den_x);
        q <= {q[NORM_W-2:0], 1'b1};
      end else begin
        r <= ROOT_W'(r2);
        q <= {q[NORM_W-2:0], 1'b0};
      end
    end else if (ctrl.div_round) begin
      if (r2 >= den_x) begin
        q <= q + NORM_W'(1);
      end
    end
    if (ctrl.dot) begin
      prod <= PROD_W'(v0) * PROD_W'(n);
    end
  end

endmodule

// File: src/tpb_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module tpb_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tpb_pkg::RAD_W-1:0]  radicand,
  output logic                       done,
  output logic [tpb_pkg::ROOT_W-1:0] root
);
  import tpb_pkg::*;

  localparam int STEPS = RAD_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [RAD_W-1:0] rem;
  logic [RAD_W-1:0] res;
  logic [RAD_W-1:0] bit_r;
  logic [RAD_W-1:0] trial;

  assign trial = res + bit_r;
  assign root  = res[ROOT_W-1:0];

  // Control: run a fixed number of steps after start.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(STEPS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Datapath: one digit of the root per step.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= radicand;
      res   <= '0;
      bit_r <= {2'b01, {(RAD_W-2){1'b0}}};
    end else if (active) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bit_r;
      end else begin
        res <= res >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

// File: src/tpb_bounds.sv
// Running axis-aligned bounding box, one compare lane per axis.
module tpb_bounds (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  logic           start_mesh,
  input  tpb_pkg::vec3_t v0,
  input  tpb_pkg::vec3_t v1,
  input  tpb_pkg::vec3_t v2,
  output tpb_pkg::vec3_t box_min,
  output tpb_pkg::vec3_t box_max
);
  import tpb_pkg::*;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    coord_t lo0, lo1, lo2, lo3;
    coord_t hi0, hi1, hi2, hi3;

    // Fold the three vertices into the box, starting fresh on a new mesh.
    always_comb begin
      lo0 = start_mesh ? COORD_MAX : box_min[k];
      hi0 = start_mesh ? COORD_MIN : box_max[k];
      lo1 = (v0[k] < lo0) ? v0[k] : lo0;
      hi1 = (v0[k] > hi0) ? v0[k] : hi0;
      lo2 = (v1[k] < lo1) ? v1[k] : lo1;
      hi2 = (v1[k] > hi1) ? v1[k] : hi1;
      lo3 = (v2[k] < lo2) ? v2[k] : lo2;
      hi3 = (v2[k] > hi2) ? v2[k] : hi2;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        box_min[k] <= COORD_MAX;
        box_max[k] <= COORD_MIN;
      end else if (load) begin
        box_min[k] <= lo3;
        box_max[k] <= hi3;
      end
    end
  end

endmodule

// File: src/triangle_plane_and_bounds_unit.sv
// Top level of the triangle plane and bounds unit: sequencer, lanes and merge.
// Each triangle request yields its unit face normal (Q2.30), its plane distance
// (Q16.16, saturated), a degenerate flag and the bounding box over all vertices
// since reset or the last start_mesh. One triangle is worked on at a time. The
// cross product is scaled down by one-bit shifts until all axes fit, then the
// 32-step square root unit and the 30-step per-lane division give the normal;
// a degenerate triangle goes from the shift step straight to the output. A
// finished result waits in the output register while the next request is
// accepted.
module triangle_plane_and_bounds_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tpb_pkg::coord_t v0_x,
  input  tpb_pkg::coord_t v0_y,
  input  tpb_pkg::coord_t v0_z,
  input  tpb_pkg::coord_t v1_x,
  input  tpb_pkg::coord_t v1_y,
  input  tpb_pkg::coord_t v1_z,
  input  tpb_pkg::coord_t v2_x,
  input  tpb_pkg::coord_t v2_y,
  input  tpb_pkg::coord_t v2_z,
  input  logic            start_mesh,
  output logic            out_valid,
  input  logic            out_ready,
  output tpb_pkg::norm_t  normal_x,
  output tpb_pkg::norm_t  normal_y,
  output tpb_pkg::norm_t  normal_z,
  output tpb_pkg::coord_t plane_dist,
  output tpb_pkg::coord_t min_x,
  output tpb_pkg::coord_t min_y,
  output tpb_pkg::coord_t min_z,
  output tpb_pkg::coord_t max_x,
  output tpb_pkg::coord_t max_y,
  output tpb_pkg::coord_t max_z,
  output logic            degenerate
);
  import tpb_pkg::*;

  state_t     state, state_next;
  lane_ctrl_t ctrl;
  logic       accept;
  logic       out_load;
  logic       sqrt_start;
  logic       sqrt_done;

  vec3_t in_v0, in_v1, in_v2;
  vec3_t box_min, box_max;
  diff_t a [3];
  diff_t b [3];
  vec3_t v0_r;
  logic  degen;
  logic [DIV_CNT_W-1:0] cnt;

  logic [2:0]               wide;
  logic [2:0]               nonzero;
  logic [SQ_W-1:0]          sq [3];
  norm_t                    n [3];
  logic signed [PROD_W-1:0] prod [3];
  logic [RAD_W-1:0]         radicand;
  logic [ROOT_W-1:0]        root;

  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_sh;
  logic [ACC_W-COORD_W:0]   acc_hi;
  coord_t                   dist_sat;

  assign in_v0 = '{v0_x, v0_y, v0_z};
  assign in_v1 = '{v1_x, v1_y, v1_z};
  assign in_v2 = '{v2_x, v2_y, v2_z};

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Box lanes update as the request is accepted.
  tpb_bounds u_bounds (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .start_mesh (start_mesh),
    .v0         (in_v0),
    .v1         (in_v1),
    .v2         (in_v2),
    .box_min    (box_min),
    .box_max    (box_max)
  );

  // One plane lane per axis.
  for (genvar k = 0; k < 3; k++) begin : g_lane
    tpb_lane u_lane (
      .clk     (clk),
      .ctrl    (ctrl),
      .a_p     (a[(k + 1) % 3]),
      .b_q     (b[(k + 2) % 3]),
      .a_r     (a[(k + 2) % 3]),
      .b_t     (b[(k + 1) % 3]),
      .den     (root),
      .v0      (v0_r[k]),
      .wide    (wide[k]),
      .nonzero (nonzero[k]),
      .sq      (sq[k]),
      .n       (n[k]),
      .prod    (prod[k])
    );
  end

  // Merge of the squares feeds the shared square root unit.
  assign radicand = RAD_W'(sq[0]) + RAD_W'(sq[1]) + RAD_W'(sq[2]);

  tpb_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (radicand),
    .done     (sqrt_done),
    .root     (root)
  );

  // Merge of the dot terms: round, scale down and saturate.
  assign acc_sh = acc >>> NFB;
  assign acc_hi = acc_sh[ACC_W-1:COORD_W-1];
  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      dist_sat = acc_sh[COORD_W-1:0];
    end else if (acc_sh[ACC_W-1]) begin
      dist_sat = COORD_MIN;
    end else begin
      dist_sat = COORD_MAX;
    end
  end

  // Sequencer next state and step strobes.
  always_comb begin
    state_next = state;
    ctrl       = '0;
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_CROSS_MUL;
      end
      S_CROSS_MUL: begin
        ctrl.cross_mul = 1'b1;
        state_next     = S_CROSS_SUB;
      end
      S_CROSS_SUB: begin
        ctrl.cross_sub = 1'b1;
        state_next     = S_ABS;
      end
      S_ABS: begin
        ctrl.take_abs = 1'b1;
        state_next    = S_SHIFT;
      end
      S_SHIFT: begin
        if (!(|nonzero)) begin
          state_next = S_OUT;
        end else if (|wide) begin
          ctrl.shift = 1'b1;
        end else begin
          state_next = S_SQUARE;
        end
      end
      S_SQUARE: begin
        ctrl.square = 1'b1;
        state_next  = S_SUM;
      end
      S_SUM: begin
        sqrt_start = 1'b1;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        if (sqrt_done) state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        ctrl.div_init = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        ctrl.div_step = 1'b1;
        if (cnt == DIV_CNT_W'(NFB - 1)) state_next = S_ROUND;
      end
      S_ROUND: begin
        ctrl.div_round = 1'b1;
        state_next     = S_DOT;
      end
      S_DOT: begin
        ctrl.dot   = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Operand, counter and merge registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < 3; k++) begin
        a[k]    <= DIFF_W'(in_v1[k]) - DIFF_W'(in_v0[k]);
        b[k]    <= DIFF_W'(in_v2[k]) - DIFF_W'(in_v1[k]);
        v0_r[k] <= in_v0[k];
      end
      degen <= 1'b0;
    end
    if (state == S_SHIFT && !(|nonzero)) begin
      degen <= 1'b1;
    end
    if (state == S_DIV_INIT) begin
      cnt <= '0;
    end else if (state == S_DIV) begin
      cnt <= cnt + DIV_CNT_W'(1);
    end
    if (state == S_ACC) begin
      acc <= ACC_W'(prod[0]) + ACC_W'(prod[1]) + ACC_W'(prod[2])
           + (ACC_W'(1) <<< (NFB - 1));
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      normal_x   <= degen ? '0 : n[0];
      normal_y   <= degen ? '0 : n[1];
      normal_z   <= degen ? '0 : n[2];
      plane_dist <= degen ? '0 : dist_sat;
      degenerate <= degen;
      min_x      <= box_min[0];
      min_y      <= box_min[1];
      min_z      <= box_min[2];
      max_x      <= box_max[0];
      max_y      <= box_max[1];
      max_z      <= box_max[2];
    end
  end

endmodule

// File: src/tpb_checker.sv
// Port-level checks of the triangle plane and bounds unit, bound to the top level.
`include "triangle_plane_and_bounds_unit_defines.svh"

module tpb_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input tpb_pkg::coord_t v0_x,
  input tpb_pkg::coord_t v0_y,
  input tpb_pkg::coord_t v0_z,
  input tpb_pkg::coord_t v1_x,
  input tpb_pkg::coord_t v1_y,
  input tpb_pkg::coord_t v1_z,
  input tpb_pkg::coord_t v2_x,
  input tpb_pkg::coord_t v2_y,
  input tpb_pkg::coord_t v2_z,
  input logic            start_mesh,
  input logic            out_valid,
  input logic            out_ready,
  input tpb_pkg::norm_t  normal_x,
  input tpb_pkg::norm_t  normal_y,
  input tpb_pkg::norm_t  normal_z,
  input tpb_pkg::coord_t plane_dist,
  input tpb_pkg::coord_t min_x,
  input tpb_pkg::coord_t min_y,
  input tpb_pkg::coord_t min_z,
  input tpb_pkg::coord_t max_x,
  input tpb_pkg::coord_t max_y,
  input tpb_pkg::coord_t max_z,
  input logic            degenerate
);
  import tpb_pkg::*;

  // A waiting result holds until it is taken.
  `TPB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(normal_x) && $stable(plane_dist) && $stable(min_x))
  // A degenerate result carries a zero normal and distance.
  `TPB_ASSERT_IMP(a_degen_zero, out_valid && degenerate, normal_x == 0 && normal_y == 0 && normal_z == 0 && plane_dist == 0)
  // A result's box always holds at least one vertex.
  `TPB_ASSERT_IMP(a_box_order, out_valid, min_x <= max_x && min_y <= max_y && min_z <= max_z)
  // Nothing is offered right after reset.
  `TPB_ASSERT_RST(a_rst_empty, !out_valid && in_ready)

endmodule

bind triangle_plane_and_bounds_unit tpb_checker u_tpb_checker (.*);

// File: bench/triangle_plane_and_bounds_unit_checker.sv
// Checker for the triangle plane and bounds unit: predicts each result and compares it.
`timescale 1ns / 100ps

module triangle_plane_and_bounds_unit_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  tpb_pkg::coord_t v0_x,
  input  tpb_pkg::coord_t v0_y,
  input  tpb_pkg::coord_t v0_z,
  input  tpb_pkg::coord_t v1_x,
  input  tpb_pkg::coord_t v1_y,
  input  tpb_pkg::coord_t v1_z,
  input  tpb_pkg::coord_t v2_x,
  input  tpb_pkg::coord_t v2_y,
  input  tpb_pkg::coord_t v2_z,
  input  logic            start_mesh,
  input  logic            out_valid,
  input  logic            out_ready,
  input  tpb_pkg::norm_t  normal_x,
  input  tpb_pkg::norm_t  normal_y,
  input  tpb_pkg::norm_t  normal_z,
  input  tpb_pkg::coord_t plane_dist,
  input  tpb_pkg::coord_t min_x,
  input  tpb_pkg::coord_t min_y,
  input  tpb_pkg::coord_t min_z,
  input  tpb_pkg::coord_t max_x,
  input  tpb_pkg::coord_t max_y,
  input  tpb_pkg::coord_t max_z,
  input  logic            degenerate,
  output int              fail_count,
  output int              pending
);
  import tpb_pkg::*;

  typedef struct {
    norm_t  nrm [3];
    coord_t pdist;
    coord_t lo [3];
    coord_t hi [3];
    logic   degen;
  } face_t;

  face_t  face_queue [$];
  coord_t box_lo [3];
  coord_t box_hi [3];

  assign pending = face_queue.size();

  // Integer square root, floor.
  function automatic logic [31:0] root_floor(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  // Predicts one triangle and advances the running box.
  function automatic face_t predict_face(coord_t vx [3][3], logic clear);
    face_t f;
    logic signed [34:0] ea [3];
    logic signed [34:0] eb [3];
    logic signed [127:0] cr [3];
    logic [127:0] mag [3];
    logic [63:0] s [3];
    logic [63:0] sq;
    logic [63:0] len;
    logic [63:0] q;
    logic signed [127:0] acc;
    int blen;
    int sh;
    if (clear) begin
      for (int k = 0; k < 3; k++) begin
        box_lo[k] = COORD_MAX;
        box_hi[k] = COORD_MIN;
      end
    end
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) begin
        if (vx[i][k] < box_lo[k]) box_lo[k] = vx[i][k];
        if (vx[i][k] > box_hi[k]) box_hi[k] = vx[i][k];
      end
    for (int k = 0; k < 3; k++) begin
      ea[k] = 35'(vx[1][k]) - 35'(vx[0][k]);
      eb[k] = 35'(vx[2][k]) - 35'(vx[1][k]);
    end
    cr[0] = 128'(ea[1]) * 128'(eb[2]) - 128'(ea[2]) * 128'(eb[1]);
    cr[1] = 128'(ea[2]) * 128'(eb[0]) - 128'(ea[0]) * 128'(eb[2]);
    cr[2] = 128'(ea[0]) * 128'(eb[1]) - 128'(ea[1]) * 128'(eb[0]);
    blen = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = cr[k] < 0 ? -cr[k] : cr[k];
      for (int b = 0; b < 128; b++)
        if (mag[k][b] && b + 1 > blen) blen = b + 1;
    end
    f.degen = (blen == 0);
    f.pdist = '0;
    for (int k = 0; k < 3; k++) f.nrm[k] = '0;
    if (!f.degen) begin
      sh = blen > 31 ? blen - 31 : 0;
      sq = 0;
      for (int k = 0; k < 3; k++) begin
        s[k] = 64'(mag[k] >> sh);
        sq = sq + s[k] * s[k];
      end
      len = 64'(root_floor(sq));
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        // Rounded quotient, halves away from zero.
        q = ((s[k] << (NFB + 1)) / len + 1) >> 1;
        f.nrm[k] = cr[k] < 0 ? -NORM_W'(q) : NORM_W'(q);
        acc = acc + 128'(vx[0][k]) * 128'(f.nrm[k]);
      end
      acc = (acc + (128'sd1 <<< (NFB - 1))) >>> NFB;
      if (acc > 128'(COORD_MAX)) f.pdist = COORD_MAX;
      else if (acc < 128'(COORD_MIN)) f.pdist = COORD_MIN;
      else f.pdist = coord_t'(acc);
    end
    f.lo = box_lo;
    f.hi = box_hi;
    return f;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Capture each accepted request and check each accepted result.
  always @(posedge clk) begin
    face_t f;
    coord_t vx [3][3];
    if (rst) begin
      fail_count <= 0;
      for (int k = 0; k < 3; k++) begin
        box_lo[k] = COORD_MAX;
        box_hi[k] = COORD_MIN;
      end
      face_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (face_queue.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          f = face_queue.pop_front();
          if (normal_x !== f.nrm[0]) report_mismatch("normal_x", normal_x, f.nrm[0]);
          if (normal_y !== f.nrm[1]) report_mismatch("normal_y", normal_y, f.nrm[1]);
          if (normal_z !== f.nrm[2]) report_mismatch("normal_z", normal_z, f.nrm[2]);
          if (plane_dist !== f.pdist) report_mismatch("plane_dist", plane_dist, f.pdist);
          if (min_x !== f.lo[0]) report_mismatch("min_x", min_x, f.lo[0]);
          if (min_y !== f.lo[1]) report_mismatch("min_y", min_y, f.lo[1]);
          if (min_z !== f.lo[2]) report_mismatch("min_z", min_z, f.lo[2]);
          if (max_x !== f.hi[0]) report_mismatch("max_x", max_x, f.hi[0]);
          if (max_y !== f.hi[1]) report_mismatch("max_y", max_y, f.hi[1]);
          if (max_z !== f.hi[2]) report_mismatch("max_z", max_z, f.hi[2]);
          if (degenerate !== f.degen) report_mismatch("degenerate", degenerate, f.degen);
        end
      end
      if (in_valid && in_ready) begin
        vx[0] = '{v0_x, v0_y, v0_z};
        vx[1] = '{v1_x, v1_y, v1_z};
        vx[2] = '{v2_x, v2_y, v2_z};
        face_queue.push_back(predict_face(vx, start_mesh));
      end
    end
  end
endmodule

// File: bench/triangle_plane_and_bounds_unit_test.sv
// Stimulus and verdict for the triangle plane and bounds unit.
`timescale 1ns / 100ps

module triangle_plane_and_bounds_unit_test;
  import tpb_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  logic   clk = 0;
  logic   rst = 1;
  logic   in_valid = 0;
  logic   in_ready;
  coord_t v0_x = 0, v0_y = 0, v0_z = 0;
  coord_t v1_x = 0, v1_y = 0, v1_z = 0;
  coord_t v2_x = 0, v2_y = 0, v2_z = 0;
  logic   start_mesh = 0;
  logic   out_valid;
  logic   out_ready = 0;
  norm_t  normal_x, normal_y, normal_z;
  coord_t plane_dist, min_x, min_y, min_z, max_x, max_y, max_z;
  logic   degenerate;
  int     fail_count;
  int     pending;
  int     idle_cycles = 0;
  int     stall_mode = 0;

  always #2 clk = ~clk;

  triangle_plane_and_bounds_unit uut (.*);
  triangle_plane_and_bounds_unit_checker checker_i (.*);

  // Receiver stalls: phases of always ready, random, and mostly stalled.
  always @(posedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Random coordinate: extremes, small values, or full range.
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2, 3, 4: return coord_t'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      5, 6: return coord_t'($signed($urandom_range(0, 65535)) - 32768);
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic send_triangle(coord_t a [3], coord_t b [3], coord_t c [3], logic clear);
    v0_x <= a[0]; v0_y <= a[1]; v0_z <= a[2];
    v1_x <= b[0]; v1_y <= b[1]; v1_z <= b[2];
    v2_x <= c[0]; v2_y <= c[1]; v2_z <= c[2];
    start_mesh <= clear;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random();
    coord_t a [3], b [3], c [3];
    int kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      a[k] = rand_coord();
      b[k] = rand_coord();
      c[k] = rand_coord();
    end
    // Degenerate shapes: repeated vertex or collinear points.
    if (kind == 0) b = a;
    else if (kind == 1) for (int k = 0; k < 3; k++) c[k] = b[k] + (b[k] - a[k]);
    send_triangle(a, b, c, $urandom_range(0, 7) == 0);
  endtask

  initial begin
    coord_t p0 [3], p1 [3], p2 [3];
    int burst;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed triangles: axis faces, degenerate cases, extreme coordinates.
    p0 = '{0, 0, 0}; p1 = '{32'h10000, 0, 0}; p2 = '{0, 32'h10000, 0};
    send_triangle(p0, p1, p2, 1'b1);
    p0 = '{0, 0, 32'h50000}; p1 = '{0, 32'h10000, 32'h50000}; p2 = '{32'h10000, 0, 32'h50000};
    send_triangle(p0, p1, p2, 1'b0);
    p0 = '{32'h30000, 0, 0}; p1 = '{32'h30000, 0, 32'h10000}; p2 = '{32'h30000, 32'h10000, 0};
    send_triangle(p0, p1, p2, 1'b1);
    p0 = '{1, 2, 3};
    send_triangle(p0, p0, p0, 1'b0);
    p1 = '{2, 4, 6}; p2 = '{3, 6, 9};
    send_triangle(p0, p1, p2, 1'b0);
    p0 = '{COORD_MAX, COORD_MAX, COORD_MAX}; p1 = '{COORD_MIN, COORD_MAX, COORD_MIN};
    p2 = '{COORD_MIN, COORD_MIN, COORD_MAX};
    send_triangle(p0, p1, p2, 1'b1);
    p0 = '{COORD_MIN, COORD_MIN, COORD_MIN}; p1 = '{COORD_MAX, COORD_MIN, COORD_MAX};
    p2 = '{COORD_MAX, COORD_MAX, COORD_MIN};
    send_triangle(p0, p1, p2, 1'b0);
    p0 = '{COORD_MAX, COORD_MAX, COORD_MAX}; p1 = '{COORD_MIN, COORD_MIN, COORD_MAX};
    p2 = '{COORD_MIN, COORD_MAX, COORD_MIN};
    send_triangle(p0, p1, p2, 1'b1);
    p0 = '{0, 0, 0}; p1 = '{1, 0, 0}; p2 = '{0, 1, 0};
    send_triangle(p0, p1, p2, 1'b1);
    p0 = '{-1, -1, -1}; p1 = '{0, 1, 0}; p2 = '{1, 0, 1};
    send_triangle(p0, p1, p2, 1'b0);

    // Random bursts, most of them followed by a random gap.
    for (int n = 0; n < 650; n += burst) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst; i++) send_random();
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
